// ----- rtl/ffa_pkg.sv -----
// Package for the first-fit heap allocator.
// Holds request and status codes, field widths and the sequencer state type.
// No dependencies.
package ffa_pkg;

    localparam int REQ_W     = 2;
    localparam int SIZE_W    = 32;
    localparam int ADDR_W    = 64;
    localparam int STATUS_W  = 3;
    localparam int BYTES_W   = 16;
    localparam int COUNT_W   = 12;
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 144;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DISABLED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_PTR   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_BASE   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_ARD,
        S_AEV,
        S_ASPL,
        S_FRD,
        S_FEV,
        S_MRD,
        S_MLD,
        S_MNX,
        S_MEV,
        S_SRD,
        S_SEV,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

endpackage

// ----- rtl/ffa_store.sv -----
// Block store: one synchronous memory of block headers, slot 0 in flip-flops.
// Entry layout {payload size, free mark, next link}. Uses no package items.
module ffa_store #(
    parameter int SW = 13,
    parameter int LW = 14,
    parameter int ZW = 16,
    parameter int EW = 31,
    parameter int HEAD_SIZE = 65512
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [SW-1:0] rd_addr,
    output logic [EW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [SW-1:0] wr_addr,
    input  logic [EW-1:0] wr_data
);

    logic [EW-1:0] mem [(1<<SW)];
    logic [EW-1:0] mem_rd_reg;
    logic          rd_head_reg;
    logic [EW-1:0] head_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr != '0))
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_head_reg <= 1'b0;
            head_reg    <= {ZW'(HEAD_SIZE), 1'b1, LW'(1 << SW)};
        end
        else
        begin
            if (rd_en)
            begin
                rd_head_reg <= (rd_addr == '0);
            end
            if (wr_en && (wr_addr == '0))
            begin
                head_reg <= wr_data;
            end
        end
    end

    assign rd_data = rd_head_reg ? head_reg : mem_rd_reg;

endmodule

// ----- rtl/ffa_seq.sv -----
// Request sequencer: walks the block list for allocate, free, merge and statistics.
// Depends on ffa_pkg; drives the ffa_store ports.
module ffa_seq #(
    parameter int HEAP_BYTES = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES = 8,
    parameter int MIN_PAYLOAD_BYTES = 8,
    parameter int SW = 13,
    parameter int LW = 14,
    parameter int ZW = 16,
    parameter int EW = 31
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [ffa_pkg::REQ_W-1:0]        in_req_type,
    input  logic [ffa_pkg::SIZE_W-1:0]       in_alloc_size,
    input  logic [ffa_pkg::ADDR_W-1:0]       in_block_address,
    input  logic                             heap_enable,
    input  logic [ffa_pkg::ADDR_W-1:0]       heap_base,
    input  logic                             res_take,
    output ffa_pkg::seq_stat_t               stat,
    output logic [ffa_pkg::STATUS_W-1:0]     res_status,
    output logic [ffa_pkg::ADDR_W-1:0]       res_payload_address,
    output logic [ffa_pkg::BYTES_W-1:0]      res_hole_bytes,
    output logic [ffa_pkg::BYTES_W-1:0]      res_busy_bytes,
    output logic [ffa_pkg::BYTES_W-1:0]      res_max_hole,
    output logic [ffa_pkg::COUNT_W-1:0]      res_hole_count,
    output logic [ffa_pkg::COUNT_W-1:0]      res_busy_count,
    output logic                             rd_en,
    output logic [SW-1:0]                    rd_addr,
    input  logic [EW-1:0]                    rd_data,
    output logic                             wr_en,
    output logic [SW-1:0]                    wr_addr,
    output logic [EW-1:0]                    wr_data
);

    localparam int AS = $clog2(ALIGN_BYTES);
    localparam int NW = ffa_pkg::SIZE_W + 1;
    localparam int OW = ZW + 2;
    localparam logic [LW-1:0] END_LINK = LW'(1 << SW);

    ffa_pkg::seq_state_t state_reg, state_next;
    logic [ffa_pkg::REQ_W-1:0]    req_reg;
    logic [ffa_pkg::ADDR_W-1:0]   addr_reg;
    logic [NW-1:0]                need_reg, need_next;
    logic                         en_reg;
    logic [SW-1:0]                cur_reg, cur_next;
    logic [SW-1:0]                target_reg, target_next;
    logic [SW-1:0]                cidx_reg, cidx_next;
    logic [ZW-1:0]                csize_reg, csize_next;
    logic                         cfree_reg, cfree_next;
    logic [LW-1:0]                cnext_reg, cnext_next;
    logic [ffa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [ffa_pkg::ADDR_W-1:0]   pay_reg, pay_next;
    logic [ffa_pkg::BYTES_W-1:0]  fb_reg, fb_next, ub_reg, ub_next;
    logic [ZW-1:0]                lf_reg, lf_next;
    logic [ffa_pkg::COUNT_W-1:0]  fc_reg, fc_next, uc_reg, uc_next;

    logic [ZW-1:0] d_size;
    logic          d_free;
    logic [LW-1:0] d_next;
    logic [NW:0]   d_size_x;
    logic          fits, split;
    logic [ZW:0]   step;
    logic [LW-1:0] ns_link;
    logic [ZW-1:0] rem_size;
    logic [ffa_pkg::ADDR_W-1:0] off, new_pay;
    logic          bad_ptr, misal;
    logic [ZW-1:0] hoff;
    logic [OW-1:0] a_end, b_off;
    logic          merge;
    logic [NW-1:0] need_in;

    assign d_size   = rd_data[EW-1 -: ZW];
    assign d_free   = rd_data[LW];
    assign d_next   = rd_data[LW-1:0];
    assign d_size_x = (NW+1)'(d_size);
    assign fits     = d_free && ({1'b0, need_reg} <= d_size_x);
    assign split    = ({1'b0, need_reg} + (NW+1)'(HEADER_BYTES + MIN_PAYLOAD_BYTES))
                      <= d_size_x;
    assign step     = (ZW+1)'(need_reg[ZW-1:0]) + (ZW+1)'(HEADER_BYTES);
    assign ns_link  = LW'(cur_reg) + LW'(step >> AS);
    assign rem_size = d_size - need_reg[ZW-1:0] - ZW'(HEADER_BYTES);
    assign new_pay  = heap_base + ffa_pkg::ADDR_W'({cur_reg, {AS{1'b0}}})
                      + ffa_pkg::ADDR_W'(HEADER_BYTES);

    assign off     = addr_reg - heap_base;
    assign bad_ptr = (addr_reg < heap_base)
                     || (off < ffa_pkg::ADDR_W'(HEADER_BYTES))
                     || (off >= ffa_pkg::ADDR_W'(HEAP_BYTES))
                     || (addr_reg[AS-1:0] != '0);
    assign misal   = (off[AS-1:0] != '0);
    assign hoff    = off[ZW-1:0] - ZW'(HEADER_BYTES);

    assign a_end = OW'({cidx_reg, {AS{1'b0}}}) + OW'(HEADER_BYTES) + OW'(csize_reg);
    assign b_off = OW'({cnext_reg[SW-1:0], {AS{1'b0}}});
    assign merge = cfree_reg && d_free && (a_end == b_off);

    assign need_in = (NW'(in_alloc_size) + NW'(ALIGN_BYTES - 1))
                     & ~NW'(ALIGN_BYTES - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ffa_pkg::S_IDLE && in_valid)
        begin
            req_reg  <= in_req_type;
            addr_reg <= in_block_address;
            en_reg   <= heap_enable;
        end
        need_reg   <= need_next;
        cur_reg    <= cur_next;
        target_reg <= target_next;
        cidx_reg   <= cidx_next;
        csize_reg  <= csize_next;
        cfree_reg  <= cfree_next;
        cnext_reg  <= cnext_next;
        status_reg <= status_next;
        pay_reg    <= pay_next;
        fb_reg     <= fb_next;
        ub_reg     <= ub_next;
        lf_reg     <= lf_next;
        fc_reg     <= fc_next;
        uc_reg     <= uc_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        need_next   = need_reg;
        cur_next    = cur_reg;
        target_next = target_reg;
        cidx_next   = cidx_reg;
        csize_next  = csize_reg;
        cfree_next  = cfree_reg;
        cnext_next  = cnext_reg;
        status_next = status_reg;
        pay_next    = pay_reg;
        fb_next     = fb_reg;
        ub_next     = ub_reg;
        lf_next     = lf_reg;
        fc_next     = fc_reg;
        uc_next     = uc_reg;
        rd_en       = 1'b0;
        rd_addr     = cur_reg;
        wr_en       = 1'b0;
        wr_addr     = cur_reg;
        wr_data     = {d_size, d_free, d_next};
        unique case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    need_next   = need_in;
                    status_next = ffa_pkg::ST_OK;
                    pay_next    = '0;
                    fb_next     = '0;
                    ub_next     = '0;
                    lf_next     = '0;
                    fc_next     = '0;
                    uc_next     = '0;
                    cur_next    = '0;
                    state_next  = ffa_pkg::S_CHECK;
                end
            end
            ffa_pkg::S_CHECK:
            begin
                state_next = en_reg ? ffa_pkg::S_SRD : ffa_pkg::S_DONE;
                if (req_reg == ffa_pkg::REQ_ALLOC)
                begin
                    if (!en_reg)
                    begin
                        status_next = ffa_pkg::ST_DISABLED;
                    end
                    else if (need_reg == '0)
                    begin
                        status_next = ffa_pkg::ST_DISABLED;
                    end
                    else
                    begin
                        state_next = ffa_pkg::S_ARD;
                    end
                end
                else if (req_reg == ffa_pkg::REQ_FREE)
                begin
                    if (!en_reg)
                    begin
                        status_next = ffa_pkg::ST_DISABLED;
                    end
                    else if (bad_ptr)
                    begin
                        status_next = ffa_pkg::ST_BAD_PTR;
                    end
                    else if (misal)
                    begin
                        status_next = ffa_pkg::ST_NOT_FOUND;
                    end
                    else
                    begin
                        target_next = hoff[AS +: SW];
                        state_next  = ffa_pkg::S_FRD;
                    end
                end
            end
            ffa_pkg::S_ARD:
            begin
                rd_en      = 1'b1;
                state_next = ffa_pkg::S_AEV;
            end
            ffa_pkg::S_AEV:
            begin
                if (fits)
                begin
                    pay_next = new_pay;
                    if (split)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = ns_link[SW-1:0];
                        wr_data    = {rem_size, 1'b1, d_next};
                        csize_next = need_reg[ZW-1:0];
                        cnext_next = ns_link;
                        state_next = ffa_pkg::S_ASPL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = {d_size, 1'b0, d_next};
                        cur_next   = '0;
                        state_next = ffa_pkg::S_SRD;
                    end
                end
                else if (d_next >= END_LINK)
                begin
                    status_next = ffa_pkg::ST_NO_FIT;
                    cur_next    = '0;
                    state_next  = ffa_pkg::S_SRD;
                end
                else
                begin
                    cur_next   = d_next[SW-1:0];
                    state_next = ffa_pkg::S_ARD;
                end
            end
            ffa_pkg::S_ASPL:
            begin
                wr_en      = 1'b1;
                wr_data    = {csize_reg, 1'b0, cnext_reg};
                cur_next   = '0;
                state_next = ffa_pkg::S_SRD;
            end
            ffa_pkg::S_FRD:
            begin
                rd_en      = 1'b1;
                state_next = ffa_pkg::S_FEV;
            end
            ffa_pkg::S_FEV:
            begin
                if (cur_reg == target_reg)
                begin
                    if (d_free)
                    begin
                        status_next = ffa_pkg::ST_NOT_FOUND;
                        cur_next    = '0;
                        state_next  = ffa_pkg::S_SRD;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data    = {d_size, 1'b1, d_next};
                        state_next = ffa_pkg::S_MRD;
                    end
                end
                else if (d_next >= END_LINK)
                begin
                    status_next = ffa_pkg::ST_NOT_FOUND;
                    cur_next    = '0;
                    state_next  = ffa_pkg::S_SRD;
                end
                else
                begin
                    cur_next   = d_next[SW-1:0];
                    state_next = ffa_pkg::S_FRD;
                end
            end
            ffa_pkg::S_MRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ffa_pkg::S_MLD;
            end
            ffa_pkg::S_MLD:
            begin
                cidx_next  = '0;
                csize_next = d_size;
                cfree_next = d_free;
                cnext_next = d_next;
                state_next = ffa_pkg::S_MNX;
            end
            ffa_pkg::S_MNX:
            begin
                if (cnext_reg >= END_LINK)
                begin
                    cur_next   = '0;
                    state_next = ffa_pkg::S_SRD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cnext_reg[SW-1:0];
                    state_next = ffa_pkg::S_MEV;
                end
            end
            ffa_pkg::S_MEV:
            begin
                if (merge)
                begin
                    csize_next = csize_reg + ZW'(HEADER_BYTES) + d_size;
                    cnext_next = d_next;
                    wr_en      = 1'b1;
                    wr_addr    = cidx_reg;
                    wr_data    = {csize_reg + ZW'(HEADER_BYTES) + d_size, cfree_reg, d_next};
                end
                else
                begin
                    cidx_next  = cnext_reg[SW-1:0];
                    csize_next = d_size;
                    cfree_next = d_free;
                    cnext_next = d_next;
                end
                state_next = ffa_pkg::S_MNX;
            end
            ffa_pkg::S_SRD:
            begin
                rd_en      = 1'b1;
                state_next = ffa_pkg::S_SEV;
            end
            ffa_pkg::S_SEV:
            begin
                if (d_free)
                begin
                    fc_next = fc_reg + 1'b1;
                    fb_next = fb_reg + ffa_pkg::BYTES_W'(d_size);
                    if (d_size > lf_reg)
                    begin
                        lf_next = d_size;
                    end
                end
                else
                begin
                    uc_next = uc_reg + 1'b1;
                    ub_next = ub_reg + ffa_pkg::BYTES_W'(d_size);
                end
                if (d_next >= END_LINK)
                begin
                    state_next = ffa_pkg::S_DONE;
                end
                else
                begin
                    cur_next   = d_next[SW-1:0];
                    state_next = ffa_pkg::S_SRD;
                end
            end
            ffa_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = ffa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffa_pkg::S_IDLE;
            end
        endcase
    end

    assign stat.idle           = (state_reg == ffa_pkg::S_IDLE);
    assign stat.done           = (state_reg == ffa_pkg::S_DONE);
    assign res_status          = status_reg;
    assign res_payload_address = pay_reg;
    assign res_hole_bytes      = fb_reg;
    assign res_busy_bytes      = ub_reg;
    assign res_max_hole        = ffa_pkg::BYTES_W'(lf_reg);
    assign res_hole_count      = fc_reg;
    assign res_busy_count      = uc_reg;

`ifndef SYNTHESIS
    a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en && (rd_addr == wr_addr)))
        else $error("read and write of the same slot in one cycle");
    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffa_pkg::S_AEV) |-> $past(state_reg == ffa_pkg::S_ARD))
        else $error("allocate evaluation without a read");
    a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ffa_pkg::S_DONE && status_reg != ffa_pkg::ST_OK)
        |-> (pay_reg == '0))
        else $error("payload address on a failed request");
`endif

endmodule

// ----- rtl/first_fit_heap_allocator_top.sv -----
// Top level of the first-fit heap allocator: stream ports, configuration
// registers and result register. Depends on ffa_pkg, ffa_store and ffa_seq.
//
// Usage: one request beat on the slave stream (allocate, free or statistics)
// yields one result beat on the master stream carrying status, payload
// address and usage statistics. A new request is taken only when the
// previous one has finished its list walks; a finished result waits in the
// output register while the next request is accepted and processed.
// Each visited block costs a read and an evaluate. Statistics only, zero
// size and bad pointer: a statistics walk over the list. Disabled heap: no
// walk. Allocate: a walk up to the fit, an extra write when the block
// splits, then the statistics walk; no fit: a full walk, then the statistics
// walk. Free: a walk up to the target, a merge pass, then the statistics
// walk; not found: the walk, then the statistics walk. The next request can
// be accepted in the cycle after the result moves into the output register,
// so the list length sets the throughput. Reset leaves one free block
// spanning the heap, heap enabled and the base at 0x50000000; no clearing
// pass is needed. When the receiver stalls the result holds in the output
// register and the sequencer waits at its end. Configuration writes take
// effect at once. The user must write only while idle; the block does not enforce it.
module first_fit_heap_allocator_top #(
    parameter int HEAP_BYTES = 65536,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES = 8,
    parameter int MIN_PAYLOAD_BYTES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // req_type[1:0], alloc_size[33:2], block_address[97:34], zero pad
    input  logic [ffa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[2:0], payload_address[66:3], hole bytes[82:67], busy bytes[98:83],
    // max hole[114:99], hole count[126:115], busy count[138:127], zero pad
    output logic [ffa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_wen,
    input  logic                              cfg_index,
    input  logic [ffa_pkg::ADDR_W-1:0]        cfg_data
);

    localparam int SLOTS = HEAP_BYTES / ALIGN_BYTES;
    localparam int SW = $clog2(SLOTS);
    localparam int LW = SW + 1;
    localparam int ZW = $clog2(HEAP_BYTES);
    localparam int EW = ZW + 1 + LW;

    logic                        enable_reg;
    logic [ffa_pkg::ADDR_W-1:0]  base_reg;
    logic                        mvalid_reg;
    logic [ffa_pkg::OUT_DATA_W-1:0] mdata_reg;

    ffa_pkg::seq_stat_t          stat;
    logic                        res_take;
    logic [ffa_pkg::STATUS_W-1:0] r_status;
    logic [ffa_pkg::ADDR_W-1:0]  r_pay;
    logic [ffa_pkg::BYTES_W-1:0] r_fb, r_ub, r_lf;
    logic [ffa_pkg::COUNT_W-1:0] r_fc, r_uc;

    logic          rd_en, wr_en;
    logic [SW-1:0] rd_addr, wr_addr;
    logic [EW-1:0] rd_data, wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b1;
            base_reg   <= 64'h0000_0000_5000_0000;
        end
        else if (cfg_wen)
        begin
            if (cfg_index == ffa_pkg::CFG_ENABLE)
            begin
                enable_reg <= cfg_data[0];
            end
            else
            begin
                base_reg <= cfg_data;
            end
        end
    end

    assign res_take = stat.done && (!mvalid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mvalid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            mvalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            mvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            mdata_reg <= {5'd0, r_uc, r_fc, r_lf, r_ub, r_fb, r_pay, r_status};
        end
    end

    assign s_axis_tready = stat.idle;
    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = mdata_reg;

    ffa_seq #(
        .HEAP_BYTES        (HEAP_BYTES),
        .HEADER_BYTES      (HEADER_BYTES),
        .ALIGN_BYTES       (ALIGN_BYTES),
        .MIN_PAYLOAD_BYTES (MIN_PAYLOAD_BYTES),
        .SW                (SW),
        .LW                (LW),
        .ZW                (ZW),
        .EW                (EW)
    ) u_seq (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (s_axis_tvalid),
        .in_req_type         (s_axis_tdata[1:0]),
        .in_alloc_size       (s_axis_tdata[33:2]),
        .in_block_address    (s_axis_tdata[97:34]),
        .heap_enable         (enable_reg),
        .heap_base           (base_reg),
        .res_take            (res_take),
        .stat                (stat),
        .res_status          (r_status),
        .res_payload_address (r_pay),
        .res_hole_bytes      (r_fb),
        .res_busy_bytes      (r_ub),
        .res_max_hole        (r_lf),
        .res_hole_count      (r_fc),
        .res_busy_count      (r_uc),
        .rd_en               (rd_en),
        .rd_addr             (rd_addr),
        .rd_data             (rd_data),
        .wr_en               (wr_en),
        .wr_addr             (wr_addr),
        .wr_data             (wr_data)
    );

    ffa_store #(
        .SW        (SW),
        .LW        (LW),
        .ZW        (ZW),
        .EW        (EW),
        .HEAD_SIZE (HEAP_BYTES - HEADER_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

// ----- dv/ffa_checker.sv -----
// Checker for the first-fit heap allocator: watches the request, result and
// configuration ports, predicts each result from its own copy of the heap list
// and compares field by field. Depends on ffa_pkg.
module ffa_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [ffa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [ffa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           cfg_wen,
    input  logic                           cfg_index,
    input  logic [ffa_pkg::ADDR_W-1:0]     cfg_data,
    output int                             errors,
    output int                             pending
);
    import ffa_pkg::*;

    localparam int HEAP   = 65536;
    localparam int HDR    = 24;
    localparam int ALIGN  = 8;
    localparam int MINPAY = 8;
    localparam int NSLOT  = HEAP / ALIGN;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [BYTES_W-1:0]  free_b;
        logic [BYTES_W-1:0]  used_b;
        logic [BYTES_W-1:0]  largest;
        logic [COUNT_W-1:0]  free_n;
        logic [COUNT_W-1:0]  used_n;
    } heap_result_t;

    bit [15:0]     blk_size [NSLOT];
    bit            blk_free [NSLOT];
    bit [13:0]     blk_next [NSLOT];
    bit            enabled;
    bit [63:0]     base;
    heap_result_t  result_q[$];

    function automatic void coalesce();
        int cur;
        int nx;
        int guard;
        cur = 0;
        guard = 0;
        while (cur < NSLOT && guard <= 2 * NSLOT)
        begin
            nx = blk_next[cur];
            guard++;
            if (nx >= NSLOT)
                break;
            if (blk_free[cur] && blk_free[nx]
                && cur * ALIGN + HDR + blk_size[cur] == nx * ALIGN)
            begin
                blk_size[cur] = blk_size[cur] + HDR + blk_size[nx];
                blk_next[cur] = blk_next[nx];
                continue;
            end
            cur = nx;
        end
    endfunction

    function automatic logic [STATUS_W-1:0] allocate(bit [31:0] size, output bit [63:0] addr);
        longint unsigned need;
        longint unsigned noff;
        int cur;
        int guard;
        int ns;
        addr = 0;
        if (size == 0)
            return ST_DISABLED;
        need = ((longint'(size) + ALIGN - 1) / ALIGN) * ALIGN;
        cur = 0;
        guard = 0;
        while (cur < NSLOT && guard < NSLOT)
        begin
            guard++;
            if (blk_free[cur] && blk_size[cur] >= need)
            begin
                if (blk_size[cur] >= need + HDR + MINPAY)
                begin
                    noff = cur * ALIGN + HDR + need;
                    ns = int'(noff / ALIGN);
                    if (ns < NSLOT)
                    begin
                        blk_size[ns] = blk_size[cur] - need - HDR;
                        blk_free[ns] = 1;
                        blk_next[ns] = blk_next[cur];
                        blk_size[cur] = need;
                        blk_next[cur] = ns;
                    end
                end
                blk_free[cur] = 0;
                addr = base + cur * ALIGN + HDR;
                return ST_OK;
            end
            cur = blk_next[cur];
        end
        return ST_NO_FIT;
    endfunction

    function automatic logic [STATUS_W-1:0] release_block(bit [63:0] addr);
        bit [63:0] off;
        bit [63:0] hoff;
        int target;
        int cur;
        int guard;
        if (addr < base)
            return ST_BAD_PTR;
        off = addr - base;
        if (off < HDR || off >= HEAP || addr % ALIGN != 0)
            return ST_BAD_PTR;
        hoff = off - HDR;
        if (hoff % ALIGN != 0)
            return ST_NOT_FOUND;
        target = int'(hoff / ALIGN);
        cur = 0;
        guard = 0;
        while (cur < NSLOT && guard < NSLOT)
        begin
            guard++;
            if (cur == target)
                break;
            cur = blk_next[cur];
        end
        if (cur != target || blk_free[cur])
            return ST_NOT_FOUND;
        blk_free[cur] = 1;
        coalesce();
        return ST_OK;
    endfunction

    function automatic heap_result_t predict(logic [IN_DATA_W-1:0] d);
        heap_result_t r;
        bit [1:0] req;
        bit [63:0] a;
        int cur;
        int guard;
        int fb;
        int ub;
        int lf;
        int fc;
        int uc;
        req = d[1:0];
        r.status = ST_OK;
        r.addr = 0;
        if (req == REQ_ALLOC)
        begin
            if (!enabled)
                r.status = ST_DISABLED;
            else
                r.status = allocate(d[33:2], a);
            if (r.status == ST_OK)
                r.addr = a;
        end
        else if (req == REQ_FREE)
        begin
            r.status = enabled ? release_block(d[97:34]) : ST_DISABLED;
        end
        fb = 0; ub = 0; lf = 0; fc = 0; uc = 0;
        if (enabled)
        begin
            cur = 0;
            guard = 0;
            while (cur < NSLOT && guard < NSLOT)
            begin
                guard++;
                if (blk_free[cur])
                begin
                    fc++;
                    fb += blk_size[cur];
                    if (blk_size[cur] > lf)
                        lf = blk_size[cur];
                end
                else
                begin
                    uc++;
                    ub += blk_size[cur];
                end
                cur = blk_next[cur];
            end
        end
        r.free_b = fb[15:0];
        r.used_b = ub[15:0];
        r.largest = lf[15:0];
        r.free_n = fc[11:0];
        r.used_n = uc[11:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        heap_result_t e;
        heap_result_t g;
        if (!rst_n)
        begin
            blk_size[0] = HEAP - HDR;
            blk_free[0] = 1;
            blk_next[0] = NSLOT;
            enabled = 1;
            base = 64'h5000_0000;
            result_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_index == CFG_ENABLE)
                    enabled = cfg_data[0];
                else
                    base = cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                g.status  = m_axis_tdata[2:0];
                g.addr    = m_axis_tdata[66:3];
                g.free_b  = m_axis_tdata[82:67];
                g.used_b  = m_axis_tdata[98:83];
                g.largest = m_axis_tdata[114:99];
                g.free_n  = m_axis_tdata[126:115];
                g.used_n  = m_axis_tdata[138:127];
                if (result_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    e = result_q.pop_front();
                    if (g != e)
                    begin
                        $display({"%0t: result mismatch expected st=%0d adr=%h fb=%0d",
                                  " ub=%0d lf=%0d fn=%0d un=%0d"},
                                 $time, e.status, e.addr, e.free_b, e.used_b, e.largest,
                                 e.free_n, e.used_n);
                        $display({"%0t:                   actual st=%0d adr=%h fb=%0d",
                                  " ub=%0d lf=%0d fn=%0d un=%0d"},
                                 $time, g.status, g.addr, g.free_b, g.used_b, g.largest,
                                 g.free_n, g.used_n);
                        errors++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                result_q.push_back(predict(s_axis_tdata));
            pending = result_q.size();
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the first-fit heap allocator: clock, reset, request and
// configuration stimulus, receiver stalls and the verdict.
// Depends on ffa_pkg, first_fit_heap_allocator_top and ffa_checker.
module tb_top;
    import ffa_pkg::*;

    localparam logic [REQ_W-1:0] REQ_STATS = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RSVD  = 2'd3;
    localparam int IDLE_LIMIT = 400000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wen;
    logic                  cfg_index;
    logic [ADDR_W-1:0]     cfg_data;
    int                    errors;
    int                    pending;
    int                    idle_cycles = 0;
    int                    stall = 0;
    bit                    rx_calm = 1'b0;
    bit                    tx_calm;
    bit [63:0]             cur_base;
    bit [63:0]             live_q[$];
    bit [63:0]             gone_q[$];

    first_fit_heap_allocator_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ffa_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // receiver: random stalls, rare long ones, calm stretches
    always @(posedge clk)
    begin
        if ($urandom_range(0, 499) == 0)
            rx_calm <= ~rx_calm;
        if (stall > 0)
        begin
            stall <= stall - 1;
            m_axis_tready <= 0;
        end
        else if (!rx_calm && $urandom_range(0, 79) == 0)
        begin
            stall <= $urandom_range(20, 200);
            m_axis_tready <= 0;
        end
        else
        begin
            m_axis_tready <= rx_calm || $urandom_range(0, 3) != 0;
        end
    end

    // collect granted addresses so later frees hit live blocks
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[2:0] == ST_OK
            && m_axis_tdata[66:3] != 0)
            live_q.push_back(m_axis_tdata[66:3]);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send(logic [REQ_W-1:0] req, bit [31:0] size, bit [63:0] addr);
        int gap;
        s_axis_tvalid <= 1;
        s_axis_tdata <= {6'b0, addr, size, req};
        do @(posedge clk); while (!s_axis_tready);
        gap = $urandom_range(0, 99);
        if (tx_calm || gap < 45)
            gap = 0;
        else if (gap < 96)
            gap = $urandom_range(1, 4);
        else
            gap = $urandom_range(20, 150);
        if (gap > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, bit [63:0] val);
        int i;
        drain();
        cfg_wen <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wen <= 0;
        if (idx == CFG_BASE)
        begin
            for (i = 0; i < live_q.size(); i++)
                live_q[i] = live_q[i] - cur_base + val;
            for (i = 0; i < gone_q.size(); i++)
                gone_q[i] = gone_q[i] - cur_base + val;
            cur_base = val;
        end
        @(posedge clk);
    endtask

    task automatic free_all();
        bit [63:0] a;
        drain();
        while (live_q.size() != 0)
        begin
            a = live_q.pop_front();
            gone_q.push_back(a);
            send(REQ_FREE, $urandom, a);
        end
        drain();
    endtask

    task automatic random_item();
        int pick;
        int idx;
        bit [31:0] size;
        bit [63:0] a;
        pick = $urandom_range(0, 99);
        if (pick < 50 && live_q.size() < 40)
        begin
            idx = $urandom_range(0, 99);
            if (idx < 65)
                size = $urandom_range(1, 1024);
            else if (idx < 88)
                size = $urandom_range(1, 64);
            else if (idx < 92)
                size = $urandom_range(4096, 30000);
            else if (idx < 95)
                size = $urandom;
            else if (idx < 97)
                size = 0;
            else
                size = $urandom_range(65500, 65520);
            send(REQ_ALLOC, size, $urandom & 64'hF);
        end
        else if (pick < 82 && live_q.size() != 0)
        begin
            idx = $urandom_range(0, live_q.size() - 1);
            a = live_q[idx];
            live_q.delete(idx);
            gone_q.push_back(a);
            if (gone_q.size() > 16)
                void'(gone_q.pop_front());
            send(REQ_FREE, $urandom, a);
        end
        else if (pick < 86 && gone_q.size() != 0)
        begin
            send(REQ_FREE, 0, gone_q[$urandom_range(0, gone_q.size() - 1)]);
        end
        else if (pick < 94)
        begin
            idx = $urandom_range(0, 5);
            case (idx)
                0: a = 0;
                1: a = cur_base + $urandom_range(0, 23);
                2: a = cur_base + 65536 + $urandom_range(0, 64);
                3: a = cur_base + 8 * $urandom_range(3, 8191) + $urandom_range(1, 7);
                4: a = cur_base + 8 * $urandom_range(3, 8191);
                default: a = {$urandom, $urandom};
            endcase
            send(REQ_FREE, $urandom, a);
        end
        else
        begin
            send($urandom_range(0, 1) ? REQ_STATS : REQ_RSVD, $urandom, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        int n;
        int phase;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        cfg_wen = 0;
        cfg_index = CFG_ENABLE;
        cfg_data = '0;
        tx_calm = 0;
        cur_base = 64'h5000_0000;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        write_cfg(CFG_ENABLE, 1);
        write_cfg(CFG_BASE, 64'h5000_0000);

        // directed: extremes, bad pointers, whole heap, double free
        send(REQ_STATS, 0, 0);
        send(REQ_RSVD, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send(REQ_ALLOC, 0, 0);
        send(REQ_ALLOC, 32'hFFFF_FFFF, 0);
        send(REQ_ALLOC, 65513, 0);
        send(REQ_ALLOC, 65512, 0);
        send(REQ_ALLOC, 1, 0);
        drain();
        free_all();
        send(REQ_FREE, 0, gone_q[0]);
        send(REQ_ALLOC, 65480, 0);
        send(REQ_ALLOC, 1, 0);
        send(REQ_ALLOC, 65472, 0);
        send(REQ_ALLOC, 1, 0);
        send(REQ_FREE, 0, 0);
        send(REQ_FREE, 0, cur_base + 16);
        send(REQ_FREE, 0, cur_base + 65536);
        send(REQ_FREE, 0, cur_base + 33);
        send(REQ_FREE, 0, cur_base + 4000);
        send(REQ_FREE, 0, 64'hFFFF_FFFF_FFFF_FFFF);
        free_all();
        write_cfg(CFG_ENABLE, 0);
        send(REQ_ALLOC, 8, 0);
        send(REQ_FREE, 0, cur_base + 24);
        send(REQ_STATS, 0, 0);
        write_cfg(CFG_ENABLE, 1);

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1: write_cfg(CFG_BASE, 64'h0);
                2: write_cfg(CFG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
                3: write_cfg(CFG_BASE, 64'hFFFF_FFFF_0000_0005);
                4: write_cfg(CFG_ENABLE, 0);
                5:
                begin
                    write_cfg(CFG_ENABLE, 1);
                    write_cfg(CFG_BASE, {$urandom, $urandom});
                end
                default: ;
            endcase
            for (n = 0; n < (phase == 4 ? 60 : 330); n++)
            begin
                if ($urandom_range(0, 199) == 0)
                    tx_calm = ~tx_calm;
                if (n == 150)
                    drain();
                random_item();
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
